// ===== hdl/i2cm_pkg.sv =====
// shared types, codes and constants of the i2c master byte engine
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // command codes, six and seven mean nothing and act as none
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_ADDR  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR    = 1'd1;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_ST_C    = 5'd3,
    PH_SP_A    = 5'd4,
    PH_SP_B    = 5'd5,
    PH_SP_C    = 5'd6,
    PH_WB_BIT  = 5'd7,
    PH_WB_HI   = 5'd8,
    PH_WB_AREL = 5'd9,
    PH_WB_AHI  = 5'd10,
    PH_WB_ASMP = 5'd11,
    PH_RB_REL  = 5'd12,
    PH_RB_HI   = 5'd13,
    PH_RB_SMP  = 5'd14,
    PH_RB_ACK  = 5'd15,
    PH_RB_AHI  = 5'd16,
    PH_RB_ALO  = 5'd17,
    PH_END     = 5'd18
  } phase_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [BYTE_W-1:0] data_byte;
    logic              read_not_write;
    logic              send_nack;
    logic              sda_sample;
  } in_item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive_enable;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              nack_seen;
    logic              cmd_dropped;
  } out_item_t;

  typedef struct packed {
    phase_t            phase;
    logic [3:0]        bit_count;
    logic [HALF_W-1:0] wait_count;
    logic [BYTE_W-1:0] shift;
    logic              ack_to_send;
    logic              scl;
    logic              sda;
    logic              sda_oe;
    logic [BYTE_W-1:0] rd;
    logic              nack;
  } eng_state_t;

endpackage

// ===== hdl/i2cm_line_step.sv =====
// next-state and result logic for one tick of the line engine
`timescale 1ns / 1ps

module i2cm_line_step (
  input  i2cm_pkg::eng_state_t          st,
  input  i2cm_pkg::in_item_t            item,
  input  logic [i2cm_pkg::HALF_W-1:0]   half_period,
  input  logic [i2cm_pkg::BYTE_W-1:0]   slave_addr,
  output i2cm_pkg::eng_state_t          st_nxt,
  output i2cm_pkg::out_item_t           res
);
  import i2cm_pkg::*;

  eng_state_t s;
  logic       cmd_valid;
  logic       run_delay;
  logic       done;
  logic       dropped;

  always_comb begin
    s         = st;
    dropped   = 1'b0;
    done      = 1'b0;
    run_delay = 1'b0;
    cmd_valid = (item.cmd >= CMD_START) && (item.cmd <= CMD_READ);

    // launch a new command, or flag one that arrives while busy
    if (s.phase == PH_IDLE) begin
      if (cmd_valid) begin
        s.bit_count  = '0;
        s.wait_count = '0;
        case (item.cmd)
          CMD_START: s.phase = PH_ST_A;
          CMD_STOP:  s.phase = PH_SP_A;
          CMD_WRITE: begin
            s.shift = item.data_byte;
            s.phase = PH_WB_BIT;
          end
          CMD_ADDR: begin
            s.shift = slave_addr | {{(BYTE_W-1){1'b0}}, item.read_not_write};
            s.phase = PH_WB_BIT;
          end
          default: begin
            s.shift       = '0;
            s.ack_to_send = item.send_nack;
            s.phase       = PH_RB_REL;
          end
        endcase
      end
    end else if (cmd_valid) begin
      dropped = 1'b1;
    end

    if (s.phase != PH_IDLE) begin
      if (s.wait_count != '0) begin
        s.wait_count = s.wait_count - {{(HALF_W-1){1'b0}}, 1'b1};
        if ((s.wait_count == '0) && (s.phase == PH_END)) begin
          s.phase = PH_IDLE;
          done    = 1'b1;
        end
      end else begin
        unique case (s.phase)
          PH_ST_A: begin
            s.scl = 1'b1; s.sda = 1'b1; s.sda_oe = 1'b1;
            s.phase = PH_ST_B; run_delay = 1'b1;
          end
          PH_ST_B: begin
            s.sda = 1'b0; s.phase = PH_ST_C; run_delay = 1'b1;
          end
          PH_ST_C: begin
            s.scl = 1'b0; s.phase = PH_END;
          end
          PH_SP_A: begin
            s.sda = 1'b0; s.scl = 1'b0; s.sda_oe = 1'b1;
            s.phase = PH_SP_B; run_delay = 1'b1;
          end
          PH_SP_B: begin
            s.scl = 1'b1; s.phase = PH_SP_C; run_delay = 1'b1;
          end
          PH_SP_C: begin
            s.sda = 1'b1; s.phase = PH_END;
          end
          PH_WB_BIT: begin
            // scl is left as it is ahead of the first bit
            if (s.bit_count != '0) s.scl = 1'b0;
            s.sda       = s.shift[BYTE_W-1];
            s.sda_oe    = 1'b1;
            s.phase     = PH_WB_HI;
            run_delay   = 1'b1;
          end
          PH_WB_HI: begin
            s.scl       = 1'b1;
            s.shift     = {s.shift[BYTE_W-2:0], 1'b0};
            s.bit_count = s.bit_count + 4'd1;
            s.phase     = (s.bit_count < BITS_PER_BYTE) ? PH_WB_BIT : PH_WB_AREL;
            run_delay   = 1'b1;
          end
          PH_WB_AREL: begin
            s.scl = 1'b0; s.sda_oe = 1'b0; s.phase = PH_WB_AHI; run_delay = 1'b1;
          end
          PH_WB_AHI: begin
            s.scl = 1'b1; s.phase = PH_WB_ASMP; run_delay = 1'b1;
          end
          PH_WB_ASMP: begin
            s.nack = item.sda_sample; s.scl = 1'b0;
            s.phase = PH_END; run_delay = 1'b1;
          end
          PH_RB_REL: begin
            s.sda_oe = 1'b0; s.phase = PH_RB_HI; run_delay = 1'b1;
          end
          PH_RB_HI: begin
            s.scl = 1'b1; s.phase = PH_RB_SMP; run_delay = 1'b1;
          end
          PH_RB_SMP: begin
            s.shift     = {s.shift[BYTE_W-2:0], item.sda_sample};
            s.scl       = 1'b0;
            s.bit_count = s.bit_count + 4'd1;
            if (s.bit_count < BITS_PER_BYTE) begin
              s.phase = PH_RB_HI;
            end else begin
              s.rd     = s.shift;
              s.sda_oe = 1'b1;
              s.phase  = PH_RB_ACK;
            end
            run_delay = 1'b1;
          end
          PH_RB_ACK: begin
            s.sda = s.ack_to_send; s.phase = PH_RB_AHI; run_delay = 1'b1;
          end
          PH_RB_AHI: begin
            s.scl = 1'b1; s.phase = PH_RB_ALO; run_delay = 1'b1;
          end
          PH_RB_ALO: begin
            s.scl = 1'b0; s.phase = PH_END; run_delay = 1'b1;
          end
          default: s.phase = PH_END;
        endcase
        if (run_delay) s.wait_count = half_period;
        if ((s.phase == PH_END) && (s.wait_count == '0)) begin
          s.phase = PH_IDLE;
          done    = 1'b1;
        end
      end
    end
  end

  assign st_nxt = s;

  always_comb begin
    res.scl_level        = s.scl;
    res.sda_level        = s.sda;
    res.sda_drive_enable = s.sda_oe;
    res.busy_res         = (s.phase != PH_IDLE);
    res.done_res         = done;
    res.read_data        = s.rd;
    res.nack_seen        = s.nack;
    res.cmd_dropped      = dropped;
  end

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// top level of the i2c master byte engine: input register, line step, result register
`timescale 1ns / 1ps

// Each input transaction is one bit-timing tick: it carries the sampled SDA level and an
// optional command (start, stop, write byte, write device address, read byte), and yields
// exactly one result transaction with the SCL/SDA driver levels, busy, done, the last read
// byte, the last sampled ACK and a dropped-command flag. Each tick goes through the input
// register, the single line-state step and the result register, and the engine sustains
// one tick per cycle while the result side does not stall. Stalls on the result side hold
// the engine and backpressure the input through in_ready. The two
// configuration registers (half period in ticks, device address byte) are written through
// cfg_we/cfg_index/cfg_wdata and should only change while the engine is idle.
module i2c_master_byte_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  i2cm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output i2cm_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::HALF_W-1:0]    cfg_wdata
);
  import i2cm_pkg::*;

  // configuration
  logic [HALF_W-1:0] half_period_r;
  logic [BYTE_W-1:0] slave_addr_r;

  // input stage
  logic      in_valid_r;
  in_item_t  in_data_r;

  // engine state and result stage
  eng_state_t state_r;
  eng_state_t state_nxt;
  out_item_t  res_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;

  // a tick advances when its result has room to land
  logic advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= '0;
      slave_addr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: half_period_r <= cfg_wdata;
        REG_DEV_ADDR:    slave_addr_r  <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register, refilled whenever it empties or drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_data_r <= in_data;
  end

  i2cm_line_step u_step (
    .st          (state_r),
    .item        (in_data_r),
    .half_period (half_period_r),
    .slave_addr  (slave_addr_r),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  // engine state moves only when a tick is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_IDLE;
      state_r.bit_count   <= '0;
      state_r.wait_count  <= '0;
      state_r.shift       <= '0;
      state_r.ack_to_send <= 1'b0;
      state_r.scl         <= 1'b1;
      state_r.sda         <= 1'b1;
      state_r.sda_oe      <= 1'b1;
      state_r.rd          <= '0;
      state_r.nack        <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register, empties on the output transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/i2cm_checker.sv =====
// port-level checks of the i2c master byte engine, bound to the top level
`timescale 1ns / 1ps

module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a finishing tick leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy together");

  // a command can only be dropped while a sequence is running or just finishing
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmd_dropped |-> out_data.busy_res || out_data.done_res)
    else $error("command dropped while idle");

  // no result is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb_i2c_master_byte_engine.sv =====
// self-checking testbench of the i2c master byte engine: directed table, then random bus traffic
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  // command codes the block treats as no command
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  // time for a tick to pass the input and result registers, plus margin
  localparam int unsigned DRAIN_CYCLES = 8;

  // line state seen while idle right after reset:
  // scl, sda, sda_oe, busy, done, read byte, nack, dropped
  localparam out_item_t IDLE_LINE = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};

  typedef struct packed {
    in_item_t   stim;
    logic [4:0] reps;
    logic       known;
    out_item_t  line;
  } row_t;

  // opening rows, all at reset configuration (no wait, device address zero);
  // rows marked known carry a typed line state, the rest go through the line predictor
  localparam row_t OPENING [19] = '{
    // idle tick with every field low
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b0}, 5'd1,  1'b1, IDLE_LINE},
    // unused codes behave as no command and are never flagged
    '{'{CMD_SPARE6, 8'hFF, 1'b1, 1'b1, 1'b1}, 5'd1,  1'b1, IDLE_LINE},
    '{'{CMD_SPARE7, 8'hFF, 1'b1, 1'b1, 1'b1}, 5'd1,  1'b1, IDLE_LINE},
    // start: first group raises both lines and the driver
    '{'{CMD_START,  8'h00, 1'b0, 1'b0, 1'b0}, 5'd1,  1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
    // command while busy is dropped, start pulls sda low
    '{'{CMD_STOP,   8'hFF, 1'b1, 1'b1, 1'b1}, 5'd1,  1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
    // command on the finishing tick is dropped too
    '{'{CMD_WRITE,  8'hA5, 1'b0, 1'b0, 1'b0}, 5'd1,  1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1}},
    // write all ones, slave answers nack
    '{'{CMD_WRITE,  8'hFF, 1'b0, 1'b0, 1'b0}, 5'd1,  1'b0, '0},
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b1}, 5'd18, 1'b0, '0},
    // address phase with read bit, slave acks
    '{'{CMD_ADDR,   8'h00, 1'b1, 1'b0, 1'b0}, 5'd1,  1'b0, '0},
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b0}, 5'd18, 1'b0, '0},
    // read all ones with ack
    '{'{CMD_READ,   8'h00, 1'b0, 1'b0, 1'b1}, 5'd1,  1'b0, '0},
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b1}, 5'd19, 1'b0, '0},
    // read all zeros with nack
    '{'{CMD_READ,   8'h00, 1'b0, 1'b1, 1'b0}, 5'd1,  1'b0, '0},
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b0}, 5'd19, 1'b0, '0},
    // write all zeros, slave acks
    '{'{CMD_WRITE,  8'h00, 1'b0, 1'b0, 1'b1}, 5'd1,  1'b0, '0},
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b0}, 5'd18, 1'b0, '0},
    // stop after a write left sda released
    '{'{CMD_STOP,   8'h00, 1'b0, 1'b0, 1'b0}, 5'd1,  1'b0, '0},
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b0}, 5'd2,  1'b0, '0},
    // back to idle, read byte zero and last ack low
    '{'{CMD_NONE,   8'h00, 1'b0, 1'b0, 1'b0}, 5'd1,  1'b1, IDLE_LINE}
  };

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HALF_PERIOD;
  logic [HALF_W-1:0]    cfg_wdata = '0;

  i2c_master_byte_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the configuration
  logic [HALF_W-1:0] half_ticks = '0;
  logic [BYTE_W-1:0] slave_addr = '0;

  // predictor copy of the engine state, reset values
  phase_t            eng_phase = PH_IDLE;
  logic [3:0]        eng_bits  = '0;
  logic [HALF_W-1:0] eng_wait  = '0;
  logic [BYTE_W-1:0] eng_shift = '0;
  logic              eng_ack   = 1'b0;
  logic              eng_scl   = 1'b1;
  logic              eng_sda   = 1'b1;
  logic              eng_oe    = 1'b1;
  logic [BYTE_W-1:0] eng_rd    = '0;
  logic              eng_nack  = 1'b0;

  out_item_t   due_lines[$];   // line states still to come out, oldest first
  out_item_t   due_head;
  int unsigned faults = 0;
  int unsigned cycles = 0;
  bit          calm     = 1'b0; // no idling on either side
  bit          hold_req = 1'b0; // ask the result side for one long hold

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one tick of the engine: command intake, then either a wait tick or one line group
  function automatic out_item_t line_tick(in_item_t t);
    out_item_t r;
    logic      is_cmd;
    logic      lag;
    r = '0;
    is_cmd = (t.cmd >= CMD_START) && (t.cmd <= CMD_READ);
    if (eng_phase == PH_IDLE) begin
      if (is_cmd) begin
        eng_bits = '0;
        eng_wait = '0;
        case (t.cmd)
          CMD_START: eng_phase = PH_ST_A;
          CMD_STOP:  eng_phase = PH_SP_A;
          CMD_WRITE: begin
            eng_shift = t.data_byte;
            eng_phase = PH_WB_BIT;
          end
          CMD_ADDR: begin
            eng_shift = slave_addr | BYTE_W'(t.read_not_write);
            eng_phase = PH_WB_BIT;
          end
          default: begin
            eng_shift = '0;
            eng_ack   = t.send_nack;
            eng_phase = PH_RB_REL;
          end
        endcase
      end
    end else if (is_cmd) begin
      r.cmd_dropped = 1'b1;
    end

    if (eng_phase != PH_IDLE) begin
      if (eng_wait != '0) begin
        eng_wait = eng_wait - 1'b1;
        if (eng_wait == '0 && eng_phase == PH_END) begin
          eng_phase  = PH_IDLE;
          r.done_res = 1'b1;
        end
      end else begin
        lag = 1'b1;
        case (eng_phase)
          PH_ST_A: begin
            eng_scl   = 1'b1;
            eng_sda   = 1'b1;
            eng_oe    = 1'b1;
            eng_phase = PH_ST_B;
          end
          PH_ST_B: begin
            eng_sda   = 1'b0;
            eng_phase = PH_ST_C;
          end
          PH_ST_C: begin
            eng_scl   = 1'b0;
            eng_phase = PH_END;
            lag       = 1'b0;
          end
          PH_SP_A: begin
            eng_sda   = 1'b0;
            eng_scl   = 1'b0;
            eng_oe    = 1'b1;
            eng_phase = PH_SP_B;
          end
          PH_SP_B: begin
            eng_scl   = 1'b1;
            eng_phase = PH_SP_C;
          end
          PH_SP_C: begin
            eng_sda   = 1'b1;
            eng_phase = PH_END;
            lag       = 1'b0;
          end
          PH_WB_BIT: begin
            // scl left as it is for the first bit
            if (eng_bits != '0) eng_scl = 1'b0;
            eng_sda   = eng_shift[BYTE_W-1];
            eng_oe    = 1'b1;
            eng_phase = PH_WB_HI;
          end
          PH_WB_HI: begin
            eng_scl   = 1'b1;
            eng_shift = {eng_shift[BYTE_W-2:0], 1'b0};
            eng_bits  = eng_bits + 1'b1;
            eng_phase = (eng_bits < BITS_PER_BYTE) ? PH_WB_BIT : PH_WB_AREL;
          end
          PH_WB_AREL: begin
            eng_scl   = 1'b0;
            eng_oe    = 1'b0;
            eng_phase = PH_WB_AHI;
          end
          PH_WB_AHI: begin
            eng_scl   = 1'b1;
            eng_phase = PH_WB_ASMP;
          end
          PH_WB_ASMP: begin
            eng_nack  = t.sda_sample;
            eng_scl   = 1'b0;
            eng_phase = PH_END;
          end
          PH_RB_REL: begin
            eng_oe    = 1'b0;
            eng_phase = PH_RB_HI;
          end
          PH_RB_HI: begin
            eng_scl   = 1'b1;
            eng_phase = PH_RB_SMP;
          end
          PH_RB_SMP: begin
            eng_shift = {eng_shift[BYTE_W-2:0], t.sda_sample};
            eng_scl   = 1'b0;
            eng_bits  = eng_bits + 1'b1;
            if (eng_bits < BITS_PER_BYTE) begin
              eng_phase = PH_RB_HI;
            end else begin
              // byte complete, take sda back for the ack bit
              eng_rd    = eng_shift;
              eng_oe    = 1'b1;
              eng_phase = PH_RB_ACK;
            end
          end
          PH_RB_ACK: begin
            eng_sda   = eng_ack;
            eng_phase = PH_RB_AHI;
          end
          PH_RB_AHI: begin
            eng_scl   = 1'b1;
            eng_phase = PH_RB_ALO;
          end
          PH_RB_ALO: begin
            eng_scl   = 1'b0;
            eng_phase = PH_END;
          end
          default: begin
            eng_phase = PH_END;
            lag       = 1'b0;
          end
        endcase
        if (lag) eng_wait = half_ticks;
        if (eng_phase == PH_END && eng_wait == '0) begin
          eng_phase  = PH_IDLE;
          r.done_res = 1'b1;
        end
      end
    end

    r.scl_level        = eng_scl;
    r.sda_level        = eng_sda;
    r.sda_drive_enable = eng_oe;
    r.busy_res         = (eng_phase != PH_IDLE);
    r.read_data        = eng_rd;
    r.nack_seen        = eng_nack;
    return r;
  endfunction

  // a tick with no command and random content everywhere else
  function automatic in_item_t quiet_tick();
    in_item_t t;
    t.cmd            = CMD_NONE;
    t.data_byte      = BYTE_W'($urandom_range(0, 255));
    t.read_not_write = 1'($urandom_range(0, 1));
    t.send_nack      = 1'($urandom_range(0, 1));
    t.sda_sample     = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // offer one tick, wait for its transaction, then queue its line state;
  // returns in the time step of acceptance with in_valid still high
  task automatic send_tick(in_item_t t, bit known = 1'b0, out_item_t line = '0);
    out_item_t predicted;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = line_tick(t);
    due_lines.push_back(known ? line : predicted);
  endtask

  // run the engine out to idle, drain every result, leave the block quiet
  task automatic settle();
    while (eng_phase != PH_IDLE) send_tick(quiet_tick());
    in_valid <= 1'b0;
    while (due_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, only called with the engine idle
  task automatic set_regs(logic [HALF_W-1:0] half, logic [BYTE_W-1:0] addr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_wdata <= half;
    @(posedge clk);
    cfg_index <= REG_DEV_ADDR;
    cfg_wdata <= HALF_W'(addr);
    @(posedge clk);
    cfg_we     <= 1'b0;
    half_ticks  = half;
    slave_addr  = addr;
  endtask

  // random bus traffic: mostly start, address, a few bytes, stop, with random
  // content; now and then a lone command, a missing start or stop, and
  // commands thrown in while the engine is busy
  task automatic run_traffic(int budget);
    logic [2:0] bus_plan[$];
    logic [2:0] step;
    in_item_t   t;
    int         spent;
    int         lull;
    int         n;
    spent = 0;
    lull  = 0;
    while (spent < budget) begin
      t = quiet_tick();
      if (eng_phase == PH_IDLE) begin
        if (lull > 0) begin
          lull--;
        end else begin
          if (bus_plan.size() == 0) begin
            if ($urandom_range(0, 9) == 0) begin
              bus_plan.push_back(3'($urandom_range(CMD_NONE, CMD_SPARE7)));
            end else begin
              if ($urandom_range(0, 7) != 0) bus_plan.push_back(CMD_START);
              bus_plan.push_back(CMD_ADDR);
              step = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
              n = $urandom_range(1, 4);
              repeat (n) bus_plan.push_back(step);
              // repeated start with the other direction
              if ($urandom_range(0, 3) == 0) begin
                bus_plan.push_back(CMD_START);
                bus_plan.push_back(CMD_ADDR);
                bus_plan.push_back(step == CMD_READ ? CMD_WRITE : CMD_READ);
              end
              if ($urandom_range(0, 7) != 0) bus_plan.push_back(CMD_STOP);
            end
          end
          t.cmd = bus_plan.pop_front();
          lull  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        end
      end else if ($urandom_range(0, 15) == 0) begin
        t.cmd = 3'($urandom_range(CMD_START, CMD_SPARE7));
      end
      // ticks whose command the engine throws away do not count
      if (!((eng_phase != PH_IDLE && t.cmd != CMD_NONE) || t.cmd > CMD_READ)) spent++;
      send_tick(t);
    end
  endtask

  task automatic phase_run(logic [HALF_W-1:0] half, logic [BYTE_W-1:0] addr, int budget,
                           bit squeeze = 1'b0);
    settle();
    set_regs(half, addr);
    hold_req = squeeze;
    run_traffic(budget);
  endtask

  // result side: ready in random runs with short stalls, one long hold on request
  initial begin : result_side
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        // engine fills up and must push back on its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if (!calm) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end
      end
    end
  end

  function automatic void match_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  // every result transaction against the oldest line state due
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (due_lines.size() == 0) begin
        $error("result transaction with no line state due");
        faults++;
      end else begin
        due_head = due_lines.pop_front();
        match_field("scl_level",        due_head.scl_level,        out_data.scl_level);
        match_field("sda_level",        due_head.sda_level,        out_data.sda_level);
        match_field("sda_drive_enable", due_head.sda_drive_enable, out_data.sda_drive_enable);
        match_field("busy_res",         due_head.busy_res,         out_data.busy_res);
        match_field("done_res",         due_head.done_res,         out_data.done_res);
        match_field("read_data",        due_head.read_data,        out_data.read_data);
        match_field("nack_seen",        due_head.nack_seen,        out_data.nack_seen);
        match_field("cmd_dropped",      due_head.cmd_dropped,      out_data.cmd_dropped);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_i2c_master_byte_engine NOT OK");
    $finish;
  end

  initial begin : stimulus
    int i;
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening table at reset configuration
    for (i = 0; i < $size(OPENING); i++) begin
      for (k = 0; k < OPENING[i].reps; k++) begin
        send_tick(OPENING[i].stim, OPENING[i].known, OPENING[i].line);
      end
    end
    settle();

    // long wait and all-ones address: one start, the wait counter runs down twice
    set_regs(HALF_W'(40), {BYTE_W{1'b1}});
    send_tick('{CMD_START, 8'h00, 1'b0, 1'b0, 1'b0});

    // random traffic over several settings; the first one carries the long hold
    phase_run('0, {BYTE_W{1'b1}}, 400, 1'b1);
    phase_run(HALF_W'(1), BYTE_W'($urandom_range(0, 255)) & 8'hFE, 250);
    phase_run(HALF_W'(2), '0, 200);
    phase_run(HALF_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)), 200);
    phase_run(HALF_W'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)), 250);
    settle();
    // last stretch with both sides always ready
    calm = 1'b1;
    phase_run('0, BYTE_W'($urandom_range(0, 255)), 300);
    settle();
    // catch stray results after the last one due
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    if (faults == 0) begin
      $display("tb_i2c_master_byte_engine OK");
    end else begin
      $display("tb_i2c_master_byte_engine NOT OK");
    end
    $finish;
  end

endmodule
